// ----- rtl/upd_pkg.sv -----
package upd_pkg;

    // Channel and ring geometry
    localparam int NUM_CHANNELS = 3;
    localparam int RING_DEPTH   = 3;
    localparam int CH_W         = 2;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RING_W       = 2;
    localparam int RING_IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Echo count and distance conversion
    localparam int PULSE_W      = 17;
    localparam int PULSE_LIMIT  = 100001;
    localparam int DIST_W       = 18;
    localparam int DIST_SCALE   = 340 / 4;           // 85
    localparam int DIST_DIV     = 58;
    localparam int SCALE_W      = 7;
    localparam int PROD_W       = PULSE_W + SCALE_W; // count * 85

    // Divide by 58 as multiply by ceil(2^30 / 58) and shift. The rounding
    // error times the largest product stays below 2^30, so the quotient
    // is exact over the whole clamped range.
    localparam int RECIP_SHIFT  = 30;
    localparam longint RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + DIST_DIV - 1) / DIST_DIV;
    localparam int RECIP_W      = 25;
    localparam int QUOT_W       = PROD_W + RECIP_W;

    // Configuration
    localparam int CFG_W        = 8;
    localparam int CNT_W        = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        REG_NEAR_LIMIT  = 2'd0,
        REG_FAR_LIMIT   = 2'd1,
        REG_ARRIVE_CNT  = 2'd2,
        REG_LEAVE_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] near_limit_cm;
        logic [CFG_W-1:0] far_limit_cm;
        logic [CFG_W-1:0] arrive_count;
        logic [CFG_W-1:0] leave_count_limit;
    } t_cfg;

endpackage

// ----- rtl/upd_cfg.sv -----
module upd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [upd_pkg::CFG_W-1:0]   i_cfg_data,
    output upd_pkg::t_cfg               o_cfg
);
    import upd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_NEAR_LIMIT:  n_cfg.near_limit_cm     = i_cfg_data;
                REG_FAR_LIMIT:   n_cfg.far_limit_cm      = i_cfg_data;
                REG_ARRIVE_CNT:  n_cfg.arrive_count      = i_cfg_data;
                REG_LEAVE_LIMIT: n_cfg.leave_count_limit = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit_cm     <= CFG_W'(10);
            r_cfg.far_limit_cm      <= CFG_W'(10);
            r_cfg.arrive_count      <= CFG_W'(5);
            r_cfg.leave_count_limit <= CFG_W'(5);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/upd_dist.sv -----
module upd_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [upd_pkg::CH_W-1:0]    i_channel,
    input  logic [upd_pkg::PULSE_W-1:0] i_pulse_count,
    output logic                        o_valid,
    output logic [upd_pkg::CH_W-1:0]    o_channel,
    output logic [upd_pkg::DIST_W-1:0]  o_distance_cm
);
    import upd_pkg::*;

    logic                r_v1;
    logic [CH_W-1:0]     r_ch1;
    logic [PROD_W-1:0]   r_prod;
    logic                r_v2;
    logic [CH_W-1:0]     r_ch2;
    logic [DIST_W-1:0]   r_dist;

    logic [PULSE_W-1:0]  w_clamped;
    logic [PROD_W-1:0]   w_prod;
    logic [QUOT_W-1:0]   w_quot;

    // Clamp at the timeout bound, then scale by 85
    assign w_clamped = (i_pulse_count > PULSE_W'(PULSE_LIMIT)) ?
                       PULSE_W'(PULSE_LIMIT) : i_pulse_count;
    assign w_prod    = PROD_W'(w_clamped) * PROD_W'(DIST_SCALE);

    // Reciprocal multiply for the divide by 58
    assign w_quot    = QUOT_W'(r_prod) * QUOT_W'(RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ch1  <= i_channel;
            r_prod <= w_prod;
            r_ch2  <= r_ch1;
            r_dist <= w_quot[RECIP_SHIFT +: DIST_W];
        end
    end

    assign o_valid       = r_v2;
    assign o_channel     = r_ch2;
    assign o_distance_cm = r_dist;

endmodule

// ----- rtl/upd_track.sv -----
module upd_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  upd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [upd_pkg::CH_W-1:0]    i_channel,
    input  logic [upd_pkg::DIST_W-1:0]  i_distance_cm,
    output logic                        o_valid,
    output logic [upd_pkg::DIST_W-1:0]  o_distance_cm,
    output logic                        o_arrived,
    output logic [upd_pkg::RING_W-1:0]  o_arrival_slot,
    output logic                        o_departed,
    output logic                        o_occupied
);
    import upd_pkg::*;

    logic [CNT_W-1:0]      r_near  [NUM_CHANNELS];
    logic [CNT_W-1:0]      r_leave [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_occ;
    logic [RING_IDX_W-1:0] r_slot;

    logic                  r_out_valid;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_arrived;
    logic [RING_W-1:0]     r_arr_slot;
    logic                  r_departed;
    logic                  r_occupied;

    logic [CH_IDX_W-1:0]   w_idx;
    logic                  w_hit;
    logic                  w_near;
    logic                  w_far;
    logic [CNT_W-1:0]      w_near_inc;
    logic                  w_arr;
    logic                  w_count_leave;
    logic [CNT_W-1:0]      w_leave_inc;
    logic                  w_dep;
    logic [CNT_W-1:0]      n_near;
    logic [CNT_W-1:0]      n_leave;
    logic                  n_occ;
    logic [RING_IDX_W-1:0] n_slot;

    assign w_idx = i_channel[CH_IDX_W-1:0];
    assign w_hit = i_valid && (i_channel < CH_W'(NUM_CHANNELS));
    assign w_near = i_distance_cm < DIST_W'(i_cfg.near_limit_cm);
    assign w_far  = i_distance_cm > DIST_W'(i_cfg.far_limit_cm);

    always_comb begin
        // Near count saturates
        w_near_inc = r_near[w_idx];
        if (w_near && (r_near[w_idx] != CNT_MAX)) begin
            w_near_inc = r_near[w_idx] + CNT_W'(1);
        end

        w_arr = (w_near_inc == i_cfg.arrive_count) && !r_occ[w_idx];

        // Leave count wraps at 8 bits until it equals the limit
        w_count_leave = (w_near_inc >= i_cfg.arrive_count) && w_far;
        w_leave_inc   = r_leave[w_idx] + CNT_W'(1);
        w_dep         = w_count_leave && (w_leave_inc == i_cfg.leave_count_limit);

        n_near  = w_near_inc;
        n_leave = r_leave[w_idx];
        n_occ   = r_occ[w_idx] | w_arr;
        if (w_count_leave) begin
            n_leave = w_leave_inc;
        end
        if (w_dep) begin
            n_near  = '0;
            n_leave = '0;
            n_occ   = 1'b0;
        end

        n_slot = r_slot;
        if (w_arr) begin
            n_slot = (r_slot == RING_IDX_W'(RING_DEPTH - 1)) ?
                     '0 : r_slot + RING_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_near[c]  <= '0;
                r_leave[c] <= '0;
            end
            r_occ       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_valid;
            if (w_hit) begin
                r_near[w_idx]  <= n_near;
                r_leave[w_idx] <= n_leave;
                r_occ[w_idx]   <= n_occ;
                r_slot         <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dist     <= i_distance_cm;
            r_arrived  <= w_hit && w_arr;
            r_arr_slot <= (w_hit && w_arr) ? RING_W'(r_slot) : '0;
            r_departed <= w_hit && w_dep;
            r_occupied <= w_hit && n_occ;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_distance_cm  = r_dist;
    assign o_arrived      = r_arrived;
    assign o_arrival_slot = r_arr_slot;
    assign o_departed     = r_departed;
    assign o_occupied     = r_occupied;

`ifndef SYNTH
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < RING_IDX_W'(RING_DEPTH))
        else $error("ring slot out of range");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_arrived) |-> (r_arr_slot == '0))
        else $error("arrival slot set without arrival");

    a_dep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_departed) |-> !r_occupied)
        else $error("channel still occupied after departure");

    a_arr_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_arrived && !r_departed) |-> r_occupied)
        else $error("arrival did not mark channel occupied");

    a_ring_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_hit && !w_arr) |=> $stable(r_slot))
        else $error("ring slot moved without arrival");
`endif

endmodule

// ----- rtl/ultrasonic_presence_detector_top.sv -----
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_channel, i_pulse_count
// result    o_valid / i_stall    o_distance_cm, o_arrived, o_arrival_slot, o_departed, o_occupied
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item per cycle sustained unless i_stall holds a result. Three registers in line:
// scale, divide by 58, then the result register where the per-channel counters update
// in place.
// Reset is synchronous, active low: clear counters, occupancy flags, ring slot and stage valids,
// and load the register defaults (10, 10, 5, 5).
// A result held under i_stall freezes every stage, bubbles too, and raises o_stall.
module ultrasonic_presence_detector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Measurement input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [upd_pkg::CH_W-1:0]    i_channel,
    input  logic [upd_pkg::PULSE_W-1:0] i_pulse_count,
    // Result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [upd_pkg::DIST_W-1:0]  o_distance_cm,
    output logic                        o_arrived,
    output logic [upd_pkg::RING_W-1:0]  o_arrival_slot,
    output logic                        o_departed,
    output logic                        o_occupied,
    // Register writes
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [upd_pkg::CFG_W-1:0]   i_cfg_data
);
    import upd_pkg::*;

    t_cfg                w_cfg;
    logic                w_adv;
    logic                w_out_valid;
    logic                w_dist_valid;
    logic [CH_W-1:0]     w_dist_ch;
    logic [DIST_W-1:0]   w_dist;

    // Advance every stage unless a finished result is being held back
    assign w_adv   = !(w_out_valid && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = w_out_valid;

    upd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Clamp, scale by 85, then divide by 58
    upd_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (i_valid),
        .i_channel     (i_channel),
        .i_pulse_count (i_pulse_count),
        .o_valid       (w_dist_valid),
        .o_channel     (w_dist_ch),
        .o_distance_cm (w_dist)
    );

    // Per-channel near/leave counting, arrival ring and result register
    upd_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_cfg          (w_cfg),
        .i_valid        (w_dist_valid),
        .i_channel      (w_dist_ch),
        .i_distance_cm  (w_dist),
        .o_valid        (w_out_valid),
        .o_distance_cm  (o_distance_cm),
        .o_arrived      (o_arrived),
        .o_arrival_slot (o_arrival_slot),
        .o_departed     (o_departed),
        .o_occupied     (o_occupied)
    );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    // Expected content of one result item
    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic              arrived;
        logic [RING_W-1:0] arrival_slot;
        logic              departed;
        logic              occupied;
    } t_presence_result;

    // What kind of reading to generate relative to the current limits
    typedef enum int {
        RD_NEAR,
        RD_FAR,
        RD_ANY
    } t_reading_kind;

    // DUT ports; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [CH_W-1:0]       i_channel     = '0;
    logic [PULSE_W-1:0]    i_pulse_count = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [DIST_W-1:0]     o_distance_cm;
    logic                  o_arrived;
    logic [RING_W-1:0]     o_arrival_slot;
    logic                  o_departed;
    logic                  o_occupied;
    logic                  i_cfg_we      = 1'b0;
    logic [1:0]            i_cfg_idx     = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;

    // Shadow copy of the register file
    logic [CFG_W-1:0]      near_lim;
    logic [CFG_W-1:0]      far_lim;
    logic [CFG_W-1:0]      arrive_n;
    logic [CFG_W-1:0]      leave_lim;

    // Shadow copy of per-channel presence state and the arrival ring pointer
    logic [CNT_W-1:0]      near_cnt  [NUM_CHANNELS];
    logic [CNT_W-1:0]      leave_cnt [NUM_CHANNELS];
    logic                  occ_flag  [NUM_CHANNELS];
    logic [RING_W-1:0]     ring_slot;

    t_presence_result      pending_results[$];

    // Traffic shaping: random gaps on each side, switched per test
    bit                    send_idle  = 1'b0;
    bit                    sink_idle  = 1'b0;
    int                    stall_left = 0;

    int                    errors        = 0;
    int                    readings_sent = 0;
    int                    results_seen  = 0;
    int                    arrivals_seen = 0;
    int                    departs_seen  = 0;
    int                    settings_used = 0;

    ultrasonic_presence_detector_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_channel      (i_channel),
        .i_pulse_count  (i_pulse_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_distance_cm  (o_distance_cm),
        .o_arrived      (o_arrived),
        .o_arrival_slot (o_arrival_slot),
        .o_departed     (o_departed),
        .o_occupied     (o_occupied),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Bring the shadow state to its post-reset values
    function automatic void clear_presence_state();
        near_lim  = 8'd10;
        far_lim   = 8'd10;
        arrive_n  = 8'd5;
        leave_lim = 8'd5;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            near_cnt[c]  = '0;
            leave_cnt[c] = '0;
            occ_flag[c]  = 1'b0;
        end
        ring_slot = '0;
    endfunction

    // Advance the shadow state by one reading and return what the block should report
    function automatic t_presence_result predict_presence(logic [CH_W-1:0] ch,
                                                          logic [PULSE_W-1:0] pc);
        t_presence_result r;
        int unsigned      clamped;
        r = '0;
        // Clamp at the echo timeout, then convert: count * 340 / 4 / 58
        clamped = (pc > PULSE_LIMIT) ? PULSE_LIMIT : pc;
        r.distance_cm = DIST_W'((clamped * 340 / 4) / 58);
        // Out-of-range channels report the distance only
        if (ch < NUM_CHANNELS) begin
            if (r.distance_cm < near_lim && near_cnt[ch] != 8'hFF)
                near_cnt[ch] = near_cnt[ch] + 8'd1;
            // Arrival is an equality test on a free channel
            if (near_cnt[ch] == arrive_n && !occ_flag[ch]) begin
                occ_flag[ch]   = 1'b1;
                r.arrived      = 1'b1;
                r.arrival_slot = ring_slot;
                ring_slot      = (ring_slot == RING_DEPTH - 1) ? '0 : ring_slot + 1'b1;
            end
            // Leave counter wraps at 8 bits if it has run past the limit
            if (near_cnt[ch] >= arrive_n && r.distance_cm > far_lim) begin
                leave_cnt[ch] = leave_cnt[ch] + 8'd1;
                if (leave_cnt[ch] == leave_lim) begin
                    leave_cnt[ch] = '0;
                    near_cnt[ch]  = '0;
                    occ_flag[ch]  = 1'b0;
                    r.departed    = 1'b1;
                end
            end
            r.occupied = occ_flag[ch];
        end
        return r;
    endfunction

    // Pulse count whose distance is at most cm
    function automatic logic [PULSE_W-1:0] pulse_at_most(int unsigned cm);
        return PULSE_W'(cm * 58 / 85);
    endfunction

    // Pulse count whose distance is at least cm
    function automatic logic [PULSE_W-1:0] pulse_at_least(int unsigned cm);
        return PULSE_W'((cm * 58 + 84) / 85);
    endfunction

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Send one reading: optional gap, then hold the item until the block takes it
    task automatic send_reading(input logic [CH_W-1:0] ch, input logic [PULSE_W-1:0] pc);
        int gap;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_channel     <= ch;
        i_pulse_count <= pc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_presence(ch, pc));
        readings_sent++;
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Three-stage pipeline: give it a few more edges to settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_NEAR_LIMIT:  near_lim  = value;
            REG_FAR_LIMIT:   far_lim   = value;
            REG_ARRIVE_CNT:  arrive_n  = value;
            REG_LEAVE_LIMIT: leave_lim = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Reprogram all four registers; only call with the pipeline empty
    task automatic set_limits(input logic [CFG_W-1:0] near_v, input logic [CFG_W-1:0] far_v,
                              input logic [CFG_W-1:0] arrive_v,
                              input logic [CFG_W-1:0] leave_v);
        wait_idle();
        write_reg(REG_NEAR_LIMIT, near_v);
        write_reg(REG_FAR_LIMIT, far_v);
        write_reg(REG_ARRIVE_CNT, arrive_v);
        write_reg(REG_LEAVE_LIMIT, leave_v);
        settings_used++;
    endtask

    // Generate one reading of the requested kind against the current limits
    task automatic send_kind(input logic [CH_W-1:0] ch, input t_reading_kind kind);
        logic [PULSE_W-1:0] pc;
        case (kind)
            RD_NEAR: begin
                if (near_lim == 0)
                    pc = PULSE_W'($urandom);
                else
                    pc = pulse_at_most($urandom_range(0, near_lim - 1));
            end
            RD_FAR: begin
                // Now and then go near or past the echo timeout
                if ($urandom_range(0, 9) == 0)
                    pc = PULSE_W'($urandom_range(PULSE_LIMIT - 5, (1 << PULSE_W) - 1));
                else
                    pc = pulse_at_least($urandom_range(far_lim + 1, far_lim + 400));
            end
            default: pc = PULSE_W'($urandom);
        endcase
        send_reading(ch, pc);
    endtask

    // Occasionally slip a stray reading on any channel, the unused one too
    task automatic maybe_send_noise(inout int sent);
        if ($urandom_range(0, 6) == 0) begin
            send_kind(CH_W'($urandom_range(0, 3)), t_reading_kind'($urandom_range(0, 2)));
            sent++;
        end
    endtask

    // Runs of near readings followed by runs of far readings on one channel,
    // with noise mixed in, until enough readings have gone out
    task automatic run_presence_traffic(input int n_items);
        int              sent;
        int              run_len;
        logic [CH_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            ch      = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            run_len = $urandom_range(0, (arrive_n + 1 > 12) ? 12 : arrive_n + 1);
            repeat (run_len) begin
                maybe_send_noise(sent);
                send_kind(ch, RD_NEAR);
                sent++;
            end
            run_len = $urandom_range(0, (leave_lim + 1 > 12) ? 12 : leave_lim + 1);
            repeat (run_len) begin
                maybe_send_noise(sent);
                send_kind(ch, RD_FAR);
                sent++;
            end
        end
    endtask

    // Defaults after reset: extreme pulse counts, the unused channel,
    // then one full arrival and departure on channel 0
    task automatic test_directed_defaults();
        send_idle = 1'b0;
        sink_idle = 1'b0;
        send_reading(2'd3, 17'd0);
        send_reading(2'd0, 17'h1FFFF);
        send_reading(2'd1, 17'd100001);
        send_reading(2'd2, 17'd100000);
        send_reading(2'd0, 17'd0);
        send_reading(2'd0, 17'd1);
        send_reading(2'd0, 17'd5);
        send_reading(2'd0, 17'd2);
        send_reading(2'd0, 17'd6);
        send_reading(2'd0, 17'h1FFFF);
        send_reading(2'd0, 17'h10000);
        send_reading(2'd0, 17'd8);
        send_reading(2'd0, 17'd5000);
        send_reading(2'd0, 17'd100002);
        send_reading(2'd3, 17'h1FFFF);
        wait_idle();
    endtask

    // Far limit below near limit and both counts at one: a mid-range
    // reading arrives and departs at once; ring slot keeps wrapping
    task automatic test_arrive_depart_same_reading();
        set_limits(8'd200, 8'd5, 8'd1, 8'd1);
        send_reading(2'd0, pulse_at_most(20));
        send_reading(2'd1, pulse_at_most(100));
        send_reading(2'd2, pulse_at_most(199));
        send_reading(2'd0, pulse_at_least(6));
        send_reading(2'd3, pulse_at_most(50));
        wait_idle();
    endtask

    // Arrive count at its top: the near counter must saturate at 255 and
    // the arrival fires exactly there
    task automatic test_saturated_arrive_count();
        set_limits(8'd255, 8'd0, 8'd255, 8'd1);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        for (int i = 0; i < 262; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_kind(CH_W'($urandom_range(0, 3)), RD_ANY);
            else
                send_reading(2'd2, (i >= 250) ? PULSE_W'($urandom_range(0, 1)) : '0);
        end
        send_reading(2'd2, 17'h1FFFF);
        send_reading(2'd2, 17'd0);
        wait_idle();
    endtask

    // Lower the leave limit below a running leave counter: the counter has
    // to wrap through 8 bits before it matches again
    task automatic test_wrapping_leave_count();
        set_limits(8'd60, 8'd30, 8'd1, 8'd255);
        send_idle = 1'b0;
        sink_idle = 1'b1;
        send_reading(2'd1, pulse_at_most(10));
        repeat (40) send_kind(2'd1, RD_FAR);
        set_limits(8'd60, 8'd30, 8'd1, 8'd3);
        send_idle = 1'b1;
        sink_idle = 1'b0;
        for (int i = 0; i < 222; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_kind(CH_W'($urandom_range(0, 3)), t_reading_kind'($urandom_range(0, 2)));
            else
                send_kind(2'd1, RD_FAR);
        end
        wait_idle();
    endtask

    // Phases with random limits (extremes first) and random idling on
    // each side, some phases at full rate
    task automatic test_random_settings();
        logic [CFG_W-1:0] near_v;
        logic [CFG_W-1:0] far_v;
        logic [CFG_W-1:0] arrive_v;
        logic [CFG_W-1:0] leave_v;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    near_v = 8'd0; far_v = 8'd255; arrive_v = 8'd1; leave_v = 8'd1;
                end
                1: begin
                    near_v = 8'd255; far_v = 8'd255; arrive_v = 8'd2; leave_v = 8'd3;
                end
                default: begin
                    near_v   = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom);
                    far_v    = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
                    arrive_v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 8));
                    leave_v  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 8));
                end
            endcase
            set_limits(near_v, far_v, arrive_v, leave_v);
            send_idle = (phase % 4) != 1;
            sink_idle = (phase % 4) != 2;
            run_presence_traffic(135);
        end
        wait_idle();
    endtask

    // Receiver stall: hold i_stall for the drawn number of cycles after each result
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_presence_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got distance %0d",
                         $time, o_distance_cm);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                report_field("distance_cm", exp_r.distance_cm, o_distance_cm);
                report_field("arrived", exp_r.arrived, o_arrived);
                report_field("arrival_slot", exp_r.arrival_slot, o_arrival_slot);
                report_field("departed", exp_r.departed, o_departed);
                report_field("occupied", exp_r.occupied, o_occupied);
            end
            results_seen++;
            if (o_arrived) arrivals_seen++;
            if (o_departed) departs_seen++;
            stall_left = sink_idle ? $urandom_range(0, 6) : 0;
        end
    end

    // Main sequence
    initial begin
        clear_presence_state();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_arrive_depart_same_reading();
        test_saturated_arrive_count();
        test_wrapping_leave_count();
        test_random_settings();

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d readings and %0d results under %0d register settings,",
                 readings_sent, results_seen, settings_used + 1);
        $display("with %0d arrivals and %0d departures on three channels plus the unused one.",
                 arrivals_seen, departs_seen);
        if (errors == 0) begin
            $display("[ultrasonic_presence_detector_top] OK");
        end else begin
            $display("[ultrasonic_presence_detector_top] ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("[ultrasonic_presence_detector_top] ERROR");
        $finish;
    end

endmodule
